/* rtl/i2c_bit_level_master_core_assert.svh */
// Assertion macros shared by the I2C master core modules.
`ifndef I2C_BIT_LEVEL_MASTER_CORE_ASSERT_SVH
`define I2C_BIT_LEVEL_MASTER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define I2CM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define I2CM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/i2cm_pkg.sv */
// Types and constants shared by the I2C master core modules.
package i2cm_pkg;

  localparam int BITS_PER_BYTE = 8;
  localparam int BIT_CNT_W     = $clog2(BITS_PER_BYTE + 1) < 4 ? 4 : $clog2(BITS_PER_BYTE + 1);
  localparam int DELAY_W       = 16;
  localparam int LIMIT_W       = 8;

  localparam logic [DELAY_W-1:0] DELAY_RESET     = 16'd2;
  localparam logic [LIMIT_W-1:0] ACK_LIMIT_RESET = 8'd250;

  // Tick queue between the front and the sequencer.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    CMD_NONE     = 3'd0,
    CMD_START    = 3'd1,
    CMD_STOP     = 3'd2,
    CMD_SEND     = 3'd3,
    CMD_READ     = 3'd4,
    CMD_WAIT_ACK = 3'd5
  } cmd_t;

  typedef enum logic [0:0] {
    CFG_DELAY_TICKS    = 1'b0,
    CFG_ACK_WAIT_LIMIT = 1'b1
  } cfg_idx_t;

  typedef enum logic [4:0] {
    PH_IDLE, PH_ST1, PH_ST2, PH_ST3, PH_SP1, PH_SP2, PH_SP3,
    PH_WA1, PH_WA2, PH_WAPOLL, PH_WAF1, PH_WAF2, PH_WAF3, PH_WALOW,
    PH_TXBIT, PH_TXHIGH, PH_RXHIGH, PH_RXLOW, PH_AK1, PH_AK2, PH_AK3, PH_AK4
  } phase_t;

  // One classified tick as it travels through the queue.
  typedef struct packed {
    cmd_t                     cmd;
    logic [BITS_PER_BYTE-1:0] wdata;
    logic                     send_ack;
    logic                     sda;
  } tick_t;

  // Queue handshake toward the sequencer.
  typedef struct packed {
    logic  valid;
    tick_t item;
  } tick_q_t;

endpackage

/* rtl/i2cm_front.sv */
// Input side: accepts tick beats, decodes the command and queues them.
`include "i2c_bit_level_master_core_assert.svh"

module i2cm_front
  import i2cm_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [2:0]               command,
  input  logic [BITS_PER_BYTE-1:0] write_data,
  input  logic                     send_ack,
  input  logic                     sda_in,
  output tick_q_t                  q_out,
  input  logic                     q_pop
);

  tick_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic [QCNT_W-1:0] count_next;
  logic              push;
  logic              pop;
  tick_t             decoded;

  // Reserved command codes become no-ops here so the sequencer never sees them.
  always_comb begin
    decoded.wdata    = write_data;
    decoded.send_ack = send_ack;
    decoded.sda      = sda_in;
    unique case (command)
      CMD_START:    decoded.cmd = CMD_START;
      CMD_STOP:     decoded.cmd = CMD_STOP;
      CMD_SEND:     decoded.cmd = CMD_SEND;
      CMD_READ:     decoded.cmd = CMD_READ;
      CMD_WAIT_ACK: decoded.cmd = CMD_WAIT_ACK;
      default:      decoded.cmd = CMD_NONE;
    endcase
  end

  assign in_ready    = (count != QCNT_W'(QUEUE_DEPTH));
  assign push        = in_valid && in_ready;
  assign pop         = q_pop && q_out.valid;
  assign q_out.valid = (count != '0);
  assign q_out.item  = entries[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + QCNT_W'(1);
    end else if (pop && !push) begin
      count_next = count - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= decoded;
    end
  end

  `I2CM_ASSERT_IMP(a_queue_bound, 1'b1, count <= QCNT_W'(QUEUE_DEPTH), "tick queue overfilled")

endmodule

/* rtl/i2cm_seq.sv */
// Bus sequencer: runs one tick per cycle while results drain, holds configuration and the result register.
`include "i2c_bit_level_master_core_assert.svh"

module i2cm_seq
  import i2cm_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [0:0]               cfg_index,
  input  logic [DELAY_W-1:0]       cfg_data,
  input  tick_q_t                  q_in,
  output logic                     q_pop,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     scl_drive,
  output logic                     sda_drive,
  output logic                     busy_res,
  output logic                     done_res,
  output logic [BITS_PER_BYTE-1:0] read_byte,
  output logic                     ack_failed
);

  logic [DELAY_W-1:0]       delay_ticks;
  logic [LIMIT_W-1:0]       ack_wait_limit;

  phase_t                   phase, phase_next;
  logic [BIT_CNT_W-1:0]     bit_count, bit_count_next;
  logic [BITS_PER_BYTE-1:0] shift_reg, shift_reg_next;
  logic [DELAY_W-1:0]       delay_count, delay_count_next;
  logic [LIMIT_W-1:0]       poll_count, poll_count_next;
  logic                     scl_level, scl_level_next;
  logic                     sda_level, sda_level_next;
  logic                     ack_flag, ack_flag_next;
  logic                     ack_choice, ack_choice_next;
  logic [BITS_PER_BYTE-1:0] rx_byte, rx_byte_next;

  logic                     step;
  logic                     step_done;
  logic                     enter_en;
  phase_t                   enter_ph;
  logic [DELAY_W-1:0]       load_val;
  logic [LIMIT_W:0]         poll_inc;
  logic [BIT_CNT_W-1:0]     bit_inc;
  tick_t                    tk;

  assign cfg_ready = 1'b1;
  assign tk        = q_in.item;
  // A tick advances when the result register is free or being drained this cycle.
  assign step      = q_in.valid && (!out_valid || out_ready);
  assign q_pop     = step;
  assign load_val  = (delay_ticks == '0) ? DELAY_W'(1) : delay_ticks;
  assign poll_inc  = {1'b0, poll_count} + (LIMIT_W + 1)'(1);
  assign bit_inc   = bit_count + BIT_CNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_ticks    <= DELAY_RESET;
      ack_wait_limit <= ACK_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DELAY_TICKS:    delay_ticks    <= cfg_data;
        CFG_ACK_WAIT_LIMIT: ack_wait_limit <= cfg_data[LIMIT_W-1:0];
        default:            ;
      endcase
    end
  end

  always_comb begin
    phase_next       = phase;
    bit_count_next   = bit_count;
    shift_reg_next   = shift_reg;
    delay_count_next = delay_count;
    poll_count_next  = poll_count;
    scl_level_next   = scl_level;
    sda_level_next   = sda_level;
    ack_flag_next    = ack_flag;
    ack_choice_next  = ack_choice;
    rx_byte_next     = rx_byte;
    step_done        = 1'b0;
    enter_en         = 1'b0;
    enter_ph         = PH_IDLE;

    if (phase == PH_IDLE) begin
      unique case (tk.cmd)
        CMD_START: begin
          enter_en = 1'b1;
          enter_ph = PH_ST1;
        end
        CMD_STOP: begin
          enter_en = 1'b1;
          enter_ph = PH_SP1;
        end
        CMD_SEND: begin
          shift_reg_next   = tk.wdata;
          bit_count_next   = '0;
          sda_level_next   = tk.wdata[BITS_PER_BYTE-1];
          phase_next       = PH_TXBIT;
          delay_count_next = load_val;
        end
        CMD_READ: begin
          shift_reg_next  = '0;
          bit_count_next  = '0;
          ack_choice_next = tk.send_ack;
          enter_en        = 1'b1;
          enter_ph        = PH_RXHIGH;
        end
        CMD_WAIT_ACK: begin
          ack_flag_next   = 1'b0;
          poll_count_next = '0;
          enter_en        = 1'b1;
          enter_ph        = PH_WA1;
        end
        default: ;
      endcase
    end else if (phase == PH_WAPOLL) begin
      if (!tk.sda) begin
        enter_en = 1'b1;
        enter_ph = PH_WALOW;
      end else if (poll_inc > {1'b0, ack_wait_limit}) begin
        // Acknowledge never came: release the bus with a stop and flag it.
        ack_flag_next   = 1'b1;
        poll_count_next = '0;
        enter_en        = 1'b1;
        enter_ph        = PH_WAF1;
      end else begin
        poll_count_next = poll_inc[LIMIT_W-1:0];
      end
    end else if (delay_count <= DELAY_W'(1)) begin
      delay_count_next = '0;
      unique case (phase)
        PH_ST1:  begin enter_en = 1'b1; enter_ph = PH_ST2; end
        PH_ST2:  begin enter_en = 1'b1; enter_ph = PH_ST3; end
        PH_SP1:  begin enter_en = 1'b1; enter_ph = PH_SP2; end
        PH_SP2:  begin enter_en = 1'b1; enter_ph = PH_SP3; end
        PH_WA1:  begin enter_en = 1'b1; enter_ph = PH_WA2; end
        PH_WAF1: begin enter_en = 1'b1; enter_ph = PH_WAF2; end
        PH_WAF2: begin enter_en = 1'b1; enter_ph = PH_WAF3; end
        PH_WAF3: begin enter_en = 1'b1; enter_ph = PH_WALOW; end
        PH_TXBIT: begin enter_en = 1'b1; enter_ph = PH_TXHIGH; end
        PH_AK1:  begin enter_en = 1'b1; enter_ph = PH_AK2; end
        PH_AK2:  begin enter_en = 1'b1; enter_ph = PH_AK3; end
        PH_ST3, PH_SP3, PH_WALOW, PH_AK4: begin
          phase_next = PH_IDLE;
          step_done  = 1'b1;
        end
        PH_WA2: begin
          phase_next      = PH_WAPOLL;
          poll_count_next = '0;
        end
        PH_TXHIGH: begin
          shift_reg_next = {shift_reg[BITS_PER_BYTE-2:0], 1'b0};
          bit_count_next = bit_inc;
          scl_level_next = 1'b0;
          if (bit_inc < BIT_CNT_W'(BITS_PER_BYTE)) begin
            sda_level_next   = shift_reg[BITS_PER_BYTE-2];
            phase_next       = PH_TXBIT;
            delay_count_next = load_val;
          end else begin
            sda_level_next = 1'b1;
            phase_next     = PH_IDLE;
            step_done      = 1'b1;
          end
        end
        PH_RXHIGH: begin
          shift_reg_next = {shift_reg[BITS_PER_BYTE-2:0], tk.sda};
          enter_en       = 1'b1;
          enter_ph       = PH_RXLOW;
        end
        PH_RXLOW: begin
          bit_count_next = bit_inc;
          enter_en       = 1'b1;
          if (bit_inc < BIT_CNT_W'(BITS_PER_BYTE)) begin
            enter_ph = PH_RXHIGH;
          end else begin
            rx_byte_next = shift_reg;
            enter_ph     = PH_AK1;
          end
        end
        PH_AK3: begin
          if (ack_choice) begin
            enter_en = 1'b1;
            enter_ph = PH_AK4;
          end else begin
            phase_next = PH_IDLE;
            step_done  = 1'b1;
          end
        end
        default: phase_next = PH_IDLE;
      endcase
    end else begin
      delay_count_next = delay_count - DELAY_W'(1);
    end

    // Entering a step applies its line levels and loads a fresh delay.
    if (enter_en) begin
      unique case (enter_ph)
        PH_ST1: begin
          sda_level_next = 1'b1;
          scl_level_next = 1'b1;
        end
        PH_ST2, PH_SP1, PH_WAF1: sda_level_next = 1'b0;
        PH_SP3, PH_WA1, PH_WAF3, PH_AK4: sda_level_next = 1'b1;
        PH_ST3, PH_WALOW, PH_RXLOW, PH_AK3: scl_level_next = 1'b0;
        PH_SP2, PH_WA2, PH_WAF2, PH_TXHIGH, PH_RXHIGH, PH_AK2: scl_level_next = 1'b1;
        PH_AK1: sda_level_next = !ack_choice_next;
        default: ;
      endcase
      phase_next       = enter_ph;
      delay_count_next = load_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      bit_count   <= '0;
      shift_reg   <= '0;
      delay_count <= '0;
      poll_count  <= '0;
      scl_level   <= 1'b1;
      sda_level   <= 1'b1;
      ack_flag    <= 1'b0;
      ack_choice  <= 1'b0;
      rx_byte     <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (step) begin
        phase       <= phase_next;
        bit_count   <= bit_count_next;
        shift_reg   <= shift_reg_next;
        delay_count <= delay_count_next;
        poll_count  <= poll_count_next;
        scl_level   <= scl_level_next;
        sda_level   <= sda_level_next;
        ack_flag    <= ack_flag_next;
        ack_choice  <= ack_choice_next;
        rx_byte     <= rx_byte_next;
        out_valid   <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      scl_drive  <= scl_level_next;
      sda_drive  <= sda_level_next;
      busy_res   <= (phase_next != PH_IDLE);
      done_res   <= step_done;
      read_byte  <= rx_byte_next;
      ack_failed <= ack_flag_next;
    end
  end

  `I2CM_ASSERT_IMP(a_done_not_busy, out_valid && done_res, !busy_res, "done beat still busy")
  `I2CM_ASSERT_IMP(a_poll_no_delay, phase == PH_WAPOLL, delay_count == '0, "delay left in poll")
  `I2CM_ASSERT_IMP(a_bit_bound, 1'b1, bit_count <= BIT_CNT_W'(BITS_PER_BYTE), "bit count overrun")
  `I2CM_ASSERT_NXT(a_step_result, step, out_valid, "tick produced no result beat")

endmodule

/* rtl/i2c_bit_level_master_core.sv */
// Top level of the tick-driven bit-level I2C master core.
// Every input beat is one bus timing tick carrying the sampled SDA level and, while
// the core is idle, a command (start, stop, send byte, read byte with ACK or NACK,
// wait for ACK); every tick yields exactly one result beat with the SCL and SDA
// drive levels (1 = released), busy, done, the last byte read and the ACK failure
// flag. The core takes one tick per clock cycle while results are taken: the sequencer
// advances its bus phase on each tick, fed by a two-entry tick queue, and its
// result register holds one result beat. While a result waits to be taken the queue
// keeps accepting input beats until it holds two ticks, and then the input stalls.
// A tick's result passes through the tick queue and is then registered in the result
// register. Configuration writes (delay ticks per bus phase, ACK poll limit) are
// always accepted and belong between commands.
module i2c_bit_level_master_core
  import i2cm_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [0:0]               cfg_index,
  input  logic [DELAY_W-1:0]       cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [2:0]               command,
  input  logic [BITS_PER_BYTE-1:0] write_data,
  input  logic                     send_ack,
  input  logic                     sda_in,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     scl_drive,
  output logic                     sda_drive,
  output logic                     busy_res,
  output logic                     done_res,
  output logic [BITS_PER_BYTE-1:0] read_byte,
  output logic                     ack_failed
);

  tick_q_t tick_q;
  logic    tick_pop;

  i2cm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .command    (command),
    .write_data (write_data),
    .send_ack   (send_ack),
    .sda_in     (sda_in),
    .q_out      (tick_q),
    .q_pop      (tick_pop)
  );

  i2cm_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .q_in       (tick_q),
    .q_pop      (tick_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .scl_drive  (scl_drive),
    .sda_drive  (sda_drive),
    .busy_res   (busy_res),
    .done_res   (done_res),
    .read_byte  (read_byte),
    .ack_failed (ack_failed)
  );

endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench for the tick-driven bit-level I2C master core.
module testbench;
  import i2cm_pkg::*;

  // Command codes with no meaning: the core ignores them while idle.
  localparam logic [2:0] CMD_RSVD6 = 3'd6;
  localparam logic [2:0] CMD_RSVD7 = 3'd7;

  localparam int SETTLE_CYCLES = 10;
  localparam int CYCLE_LIMIT   = 8_000_000;
  localparam int RANDOM_TICKS  = 250;
  localparam int FLUSH_TICKS   = 16;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] wdata;
    logic       ack;
    logic       sda;
  } bus_tick_t;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       busy;
    logic       done;
    logic [7:0] rx;
    logic       fail;
  } bus_levels_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [0:0]               cfg_index = CFG_DELAY_TICKS;
  logic [DELAY_W-1:0]       cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [2:0]               command = CMD_NONE;
  logic [BITS_PER_BYTE-1:0] write_data = '0;
  logic                     send_ack = 1'b0;
  logic                     sda_in = 1'b1;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic                     scl_drive;
  logic                     sda_drive;
  logic                     busy_res;
  logic                     done_res;
  logic [BITS_PER_BYTE-1:0] read_byte;
  logic                     ack_failed;

  i2c_bit_level_master_core u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .command    (command),
    .write_data (write_data),
    .send_ack   (send_ack),
    .sda_in     (sda_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .scl_drive  (scl_drive),
    .sda_drive  (sda_drive),
    .busy_res   (busy_res),
    .done_res   (done_res),
    .read_byte  (read_byte),
    .ack_failed (ack_failed)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Sequencer state as the bus should see it, starting from reset.
  logic [15:0] phase_ticks = DELAY_RESET;
  logic [7:0]  poll_limit  = ACK_LIMIT_RESET;
  phase_t      seq_state   = PH_IDLE;
  logic [3:0]  bits_done   = '0;
  logic [7:0]  shift_bits  = '0;
  logic [15:0] delay_left  = '0;
  logic [7:0]  high_polls  = '0;
  logic        scl_lvl     = 1'b1;
  logic        sda_lvl     = 1'b1;
  logic        nack_seen   = 1'b0;
  logic        answer_ack  = 1'b0;
  logic [7:0]  last_rx     = '0;

  bus_tick_t   pending_ticks[$];
  bus_levels_t expected_levels[$];
  int          ticks_queued = 0;
  int          ticks_taken  = 0;
  int          err_count    = 0;
  int          cycle_count  = 0;
  bit          tick_taken   = 1'b0;
  int          burst_left   = 0;
  int          gap_left     = 0;
  int          hold_left    = 0;
  bit          long_hold_done = 1'b0;
  int          rx_mode      = 0;
  int          rx_mode_left = 0;

  function automatic void reload_delay();
    delay_left = (phase_ticks == '0) ? 16'd1 : phase_ticks;
  endfunction

  function automatic void enter_phase(phase_t ph);
    case (ph)
      PH_ST1: begin
        sda_lvl = 1'b1;
        scl_lvl = 1'b1;
      end
      PH_ST2, PH_SP1, PH_WAF1: sda_lvl = 1'b0;
      PH_ST3, PH_WALOW, PH_RXLOW, PH_AK3: scl_lvl = 1'b0;
      PH_SP2, PH_WA2, PH_WAF2, PH_TXHIGH, PH_RXHIGH, PH_AK2: scl_lvl = 1'b1;
      PH_SP3, PH_WA1, PH_WAF3, PH_AK4: sda_lvl = 1'b1;
      PH_AK1: sda_lvl = !answer_ack;
      default: ;
    endcase
    seq_state = ph;
    reload_delay();
  endfunction

  function automatic logic end_sequence();
    seq_state  = PH_IDLE;
    delay_left = '0;
    return 1'b1;
  endfunction

  // Called when the delay of the current bus step runs out; returns 1 on completion.
  function automatic logic advance_phase(logic sda);
    case (seq_state)
      PH_ST1: enter_phase(PH_ST2);
      PH_ST2: enter_phase(PH_ST3);
      PH_SP1: enter_phase(PH_SP2);
      PH_SP2: enter_phase(PH_SP3);
      PH_ST3, PH_SP3, PH_WALOW, PH_AK4: return end_sequence();
      PH_WA1: enter_phase(PH_WA2);
      PH_WA2: begin
        seq_state  = PH_WAPOLL;
        high_polls = '0;
        delay_left = '0;
      end
      PH_WAF1: enter_phase(PH_WAF2);
      PH_WAF2: enter_phase(PH_WAF3);
      PH_WAF3: enter_phase(PH_WALOW);
      PH_TXBIT: enter_phase(PH_TXHIGH);
      PH_TXHIGH: begin
        shift_bits = shift_bits << 1;
        bits_done  = bits_done + 4'd1;
        scl_lvl    = 1'b0;
        if (bits_done < BITS_PER_BYTE) begin
          sda_lvl   = shift_bits[7];
          seq_state = PH_TXBIT;
          reload_delay();
        end else begin
          sda_lvl = 1'b1;
          return end_sequence();
        end
      end
      PH_RXHIGH: begin
        shift_bits = {shift_bits[6:0], sda};
        enter_phase(PH_RXLOW);
      end
      PH_RXLOW: begin
        bits_done = bits_done + 4'd1;
        if (bits_done < BITS_PER_BYTE) begin
          enter_phase(PH_RXHIGH);
        end else begin
          last_rx = shift_bits;
          enter_phase(PH_AK1);
        end
      end
      PH_AK1: enter_phase(PH_AK2);
      PH_AK2: enter_phase(PH_AK3);
      PH_AK3: begin
        if (answer_ack) begin
          enter_phase(PH_AK4);
        end else begin
          return end_sequence();
        end
      end
      default: begin
        seq_state  = PH_IDLE;
        delay_left = '0;
      end
    endcase
    return 1'b0;
  endfunction

  function automatic bus_levels_t step_bus_sequencer(bus_tick_t t);
    bus_levels_t r;
    logic [8:0]  next_polls;
    logic        finished;
    finished = 1'b0;
    if (seq_state == PH_IDLE) begin
      case (t.cmd)
        CMD_START: enter_phase(PH_ST1);
        CMD_STOP: enter_phase(PH_SP1);
        CMD_SEND: begin
          shift_bits = t.wdata;
          bits_done  = '0;
          sda_lvl    = t.wdata[7];
          seq_state  = PH_TXBIT;
          reload_delay();
        end
        CMD_READ: begin
          shift_bits = '0;
          bits_done  = '0;
          answer_ack = t.ack;
          enter_phase(PH_RXHIGH);
        end
        CMD_WAIT_ACK: begin
          nack_seen  = 1'b0;
          high_polls = '0;
          enter_phase(PH_WA1);
        end
        default: ;
      endcase
    end else if (seq_state == PH_WAPOLL) begin
      if (!t.sda) begin
        enter_phase(PH_WALOW);
      end else begin
        // One bit wider, so a limit of 255 still fails on the 256th high poll.
        next_polls = high_polls + 9'd1;
        if (next_polls > poll_limit) begin
          nack_seen  = 1'b1;
          high_polls = '0;
          enter_phase(PH_WAF1);
        end else begin
          high_polls = next_polls[7:0];
        end
      end
    end else if (delay_left <= 16'd1) begin
      delay_left = '0;
      finished   = advance_phase(t.sda);
    end else begin
      delay_left = delay_left - 16'd1;
    end
    r.scl  = scl_lvl;
    r.sda  = sda_lvl;
    r.busy = (seq_state != PH_IDLE);
    r.done = finished;
    r.rx   = last_rx;
    r.fail = nack_seen;
    return r;
  endfunction

  function automatic void compare_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endfunction

  function automatic void push_tick(logic [2:0] cmd, logic [7:0] wd, logic ack, logic sda);
    bus_tick_t t;
    t.cmd   = cmd;
    t.wdata = wd;
    t.ack   = ack;
    t.sda   = sda;
    pending_ticks.push_back(t);
    ticks_queued++;
  endfunction

  // Ticks spent while a sequence runs; the command codes they carry must be ignored.
  function automatic void push_busy_ticks(int n, int sda_fill);
    for (int i = 0; i < n; i++) begin
      push_tick(($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : CMD_NONE,
                8'($urandom), 1'($urandom),
                (sda_fill < 0) ? 1'($urandom) : 1'(sda_fill));
    end
  endfunction

  // One command followed by as many ticks as it needs at the current delay. For a
  // wait ack, highs is the number of high polls before SDA goes low; beyond the
  // limit (or negative) the acknowledge never comes. A cut sequence stops early.
  function automatic void queue_sequence(logic [2:0] cmd, logic [7:0] wd, logic ack,
                                         int highs, int sda_fill, bit cut);
    int d;
    int lim;
    d   = (phase_ticks == '0) ? 1 : int'(phase_ticks);
    lim = int'(poll_limit);
    push_tick(cmd, wd, ack, 1'($urandom));
    if (cut) begin
      push_busy_ticks($urandom_range(0, 2 * d), sda_fill);
      return;
    end
    case (cmd)
      CMD_START, CMD_STOP: push_busy_ticks(3 * d, sda_fill);
      CMD_SEND: push_busy_ticks(16 * d, sda_fill);
      CMD_READ: push_busy_ticks((ack ? 20 : 19) * d, sda_fill);
      CMD_WAIT_ACK: begin
        push_busy_ticks(2 * d, sda_fill);
        if (highs < 0 || highs > lim) begin
          push_busy_ticks(lim + 1, 1);
          push_busy_ticks(4 * d, sda_fill);
        end else begin
          push_busy_ticks(highs, 1);
          push_busy_ticks(1, 0);
          push_busy_ticks(d, sda_fill);
        end
      end
      default: ;
    endcase
    repeat ($urandom_range(0, 3)) push_tick(CMD_NONE, 8'($urandom), 1'($urandom), 1'($urandom));
  endfunction

  // Waits until every tick is through and checked, clocking the sequencer back to idle.
  task automatic settle_idle();
    forever begin
      while (pending_ticks.size() != 0 || in_valid || expected_levels.size() != 0)
        @(posedge clk);
      if (seq_state == PH_IDLE) break;
      for (int i = 0; i < FLUSH_TICKS; i++) push_tick(CMD_NONE, '0, 1'b0, 1'b0);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(cfg_idx_t idx, logic [15:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_DELAY_TICKS) begin
      phase_ticks = value;
    end else begin
      poll_limit = value[7:0];
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(logic [15:0] ticks, logic [15:0] limit);
    settle_idle();
    write_register(CFG_DELAY_TICKS, ticks);
    write_register(CFG_ACK_WAIT_LIMIT, limit);
  endtask

  // Tick driver: bursts of beats separated by random gaps.
  always @(negedge clk) begin
    bus_tick_t t;
    if (!rst && (!in_valid || tick_taken)) begin
      tick_taken = 1'b0;
      if (gap_left != 0 || pending_ticks.size() == 0) begin
        if (gap_left != 0) gap_left--;
        in_valid <= 1'b0;
      end else begin
        t = pending_ticks.pop_front();
        command    <= t.cmd;
        write_data <= t.wdata;
        send_ack   <= t.ack;
        sda_in     <= t.sda;
        in_valid   <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end
    end
  end

  // Result receiver: stall pattern changes every so often, plus one long hold-off.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!long_hold_done && ticks_taken >= 300) begin
      long_hold_done = 1'b1;
      hold_left      = 400;
      out_ready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      = $urandom_range(0, 3);
        rx_mode_left = $urandom_range(20, 200);
      end
      rx_mode_left--;
      case (rx_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        2: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= 1'($urandom);
      endcase
    end
  end

  always @(posedge clk) begin
    bus_tick_t   seen;
    bus_levels_t want;
    cycle_count++;
    if (!rst && in_valid && in_ready) begin
      seen.cmd   = command;
      seen.wdata = write_data;
      seen.ack   = send_ack;
      seen.sda   = sda_in;
      expected_levels.push_back(step_bus_sequencer(seen));
      tick_taken = 1'b1;
      ticks_taken++;
    end
    if (!rst && out_valid && out_ready) begin
      if (expected_levels.size() == 0) begin
        $error("result beat arrived with no tick waiting for it");
        err_count++;
      end else begin
        want = expected_levels.pop_front();
        compare_field("scl_drive", want.scl, scl_drive);
        compare_field("sda_drive", want.sda, sda_drive);
        compare_field("busy_res", want.busy, busy_res);
        compare_field("done_res", want.done, done_res);
        compare_field("read_byte", want.rx, read_byte);
        compare_field("ack_failed", want.fail, ack_failed);
      end
    end
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int random_start;
    int pick;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: codes that do nothing, every command, byte extremes.
    push_tick(CMD_RSVD6, 8'hFF, 1'b1, 1'b0);
    push_tick(CMD_RSVD7, 8'h00, 1'b0, 1'b1);
    push_tick(CMD_NONE, 8'h5A, 1'b1, 1'b1);
    queue_sequence(CMD_START, 8'h00, 1'b0, 0, -1, 1'b0);
    queue_sequence(CMD_SEND, 8'h00, 1'b0, 0, -1, 1'b0);
    queue_sequence(CMD_SEND, 8'hFF, 1'b1, 0, -1, 1'b0);
    queue_sequence(CMD_SEND, 8'hA5, 1'b0, 0, -1, 1'b0);
    queue_sequence(CMD_WAIT_ACK, 8'h00, 1'b0, 0, -1, 1'b0);
    queue_sequence(CMD_WAIT_ACK, 8'h00, 1'b0, 250, -1, 1'b0);
    queue_sequence(CMD_WAIT_ACK, 8'h00, 1'b0, -1, -1, 1'b0);
    queue_sequence(CMD_READ, 8'h00, 1'b1, 0, 1, 1'b0);
    queue_sequence(CMD_READ, 8'h00, 1'b0, 0, 0, 1'b0);
    queue_sequence(CMD_READ, 8'h00, 1'b1, 0, -1, 1'b0);
    // A stop offered while the start is still running must be ignored.
    queue_sequence(CMD_START, 8'h00, 1'b0, 0, -1, 1'b1);
    queue_sequence(CMD_STOP, 8'h00, 1'b0, 0, -1, 1'b0);
    queue_sequence(CMD_STOP, 8'h00, 1'b0, 0, -1, 1'b0);

    // Zero delay behaves as one tick; a zero limit fails on the first high poll.
    configure(16'd0, 16'd0);
    queue_sequence(CMD_WAIT_ACK, 8'h00, 1'b0, -1, -1, 1'b0);
    queue_sequence(CMD_WAIT_ACK, 8'h00, 1'b0, 0, -1, 1'b0);
    queue_sequence(CMD_SEND, 8'($urandom), 1'b0, 0, -1, 1'b0);
    queue_sequence(CMD_READ, 8'h00, 1'b1, 0, -1, 1'b0);

    // Largest limit: 255 high polls pass, the 256th fails.
    configure(16'd1, 16'd255);
    queue_sequence(CMD_WAIT_ACK, 8'h00, 1'b0, -1, -1, 1'b0);
    queue_sequence(CMD_WAIT_ACK, 8'h00, 1'b0, 255, -1, 1'b0);
    queue_sequence(CMD_START, 8'h00, 1'b0, 0, -1, 1'b0);
    queue_sequence(CMD_STOP, 8'h00, 1'b0, 0, -1, 1'b0);

    // A long delay; the limit write also carries junk in the upper byte.
    configure(16'd40, 16'hFF01);
    queue_sequence(CMD_STOP, 8'h00, 1'b0, 0, -1, 1'b0);

    random_start = ticks_queued;
    configure(16'd2, 16'd4);
    random_start = ticks_queued;
    while (ticks_queued - random_start < RANDOM_TICKS) begin
      configure(16'($urandom_range(0, 3)), {8'($urandom), 8'($urandom_range(0, 12))});
      repeat (12) begin
        pick = $urandom_range(0, 19);
        if (pick < 17) begin
          queue_sequence(3'(1 + pick % 5), 8'($urandom), 1'($urandom),
                         $urandom_range(0, int'(poll_limit) + 2), -1,
                         $urandom_range(0, 9) == 0);
        end else begin
          queue_sequence(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom),
                         -1, -1, 1'b1);
        end
      end
    end

    settle_idle();
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
